FILE: rtl/dtb_pkg.sv
// Package for the DMA descriptor table builder.
// Holds the shared constants, the queued command type and the entry limits.
// No dependencies.
package dtb_pkg;

    // Most descriptor entries one request may produce
    localparam int MAX_ENTRIES = 64;
    localparam int CNT_W       = $clog2(MAX_ENTRIES);

    // Largest legal byte count (0xfffff * 255)
    localparam logic [31:0] SIZE_LIMIT = 32'(20'hfffff * 255);
    // Width that holds any legal byte count
    localparam int LEFT_W = $clog2(SIZE_LIMIT + 1);

    localparam logic [16:0] BOUNDARY   = 17'h10000;
    localparam logic [15:0] HALF_CHUNK = 16'h8000;

    // Classified request passed from front end to generator
    typedef struct packed {
        logic [31:0]       addr;
        logic [LEFT_W-1:0] bytes;
        logic              err;
    } t_dtb_cmd;

    // Generator states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_dtb_state;

endpackage

FILE: rtl/dtb_front.sv
// Front end of the descriptor table builder: accepts request beats and checks them.
// Uses dtb_pkg; feeds dtb_queue.
module dtb_front
    import dtb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] buffer_address, [63:32] total_bytes
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_dtb_cmd    o_cmd
);

    logic        r_valid;
    t_dtb_cmd    r_cmd;
    t_dtb_cmd    n_cmd;
    logic [31:0] w_bytes;
    logic        w_take;

    assign w_bytes    = i_s_tdata[63:32];
    assign o_s_tready = !r_valid || i_cmd_ready;
    assign w_take     = i_s_tvalid && o_s_tready;

    // Classify: zero or oversized byte count is an error-only request
    always_comb begin
        n_cmd.addr  = i_s_tdata[31:0];
        n_cmd.bytes = w_bytes[LEFT_W-1:0];
        n_cmd.err   = (w_bytes == 32'd0) || (w_bytes > SIZE_LIMIT);
    end

    // Valid flag of the holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: rtl/dtb_queue.sv
// Two-entry command queue between front end and generator.
// Uses dtb_pkg for the command type.
module dtb_queue
    import dtb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push_valid,
    output logic     o_push_ready,
    input  t_dtb_cmd i_push_cmd,
    output logic     o_pop_valid,
    input  logic     i_pop,
    output t_dtb_cmd o_pop_cmd
);

    t_dtb_cmd   r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;
    assign o_pop_cmd    = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

FILE: rtl/dtb_engine.sv
// Back end: splits one queued request into descriptor entries, one per cycle while the output is not stalled.
// Uses dtb_pkg; drives the output register of the result stream.
module dtb_engine
    import dtb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  t_dtb_cmd    i_cmd,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [31:0] entry_address, [47:32] entry_length
    output logic        o_m_tlast,
    output logic        o_m_tuser    // error
);

    t_dtb_state        r_state;
    logic [31:0]       r_addr;
    logic [LEFT_W-1:0] r_left;
    logic              r_err;
    logic [CNT_W-1:0]  r_cnt;

    logic              r_out_valid;
    logic [31:0]       r_out_addr;
    logic [15:0]       r_out_len;
    logic              r_out_last;
    logic              r_out_err;

    logic              w_adv;
    logic              w_emit;
    logic [16:0]       w_chunk;
    logic [16:0]       w_room;
    logic [15:0]       w_piece;
    logic [LEFT_W-1:0] w_rem;
    logic              w_full;
    logic              w_last;
    logic              w_ovf;

    assign w_adv     = !r_out_valid || i_m_tready;
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign w_emit    = (r_state == ST_RUN) && w_adv;

    // Entry size: up to the next 64 KiB boundary, a full aligned chunk goes in halves
    always_comb begin
        w_room  = BOUNDARY - {1'b0, r_addr[15:0]};
        w_chunk = (r_left < LEFT_W'(w_room)) ? 17'(r_left) : w_room;
        w_piece = (w_chunk == BOUNDARY) ? HALF_CHUNK : w_chunk[15:0];
        w_rem   = r_left - LEFT_W'(w_piece);
        w_full  = (r_cnt == CNT_W'(MAX_ENTRIES - 1));
        w_ovf   = (w_rem != '0) && w_full;
        w_last  = r_err || (w_rem == '0) || w_full;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_cmd_valid) r_state <= ST_RUN;
                ST_RUN:  if (w_emit && w_last) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Working registers of the current request
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_addr <= i_cmd.addr;
            r_left <= i_cmd.bytes;
            r_err  <= i_cmd.err;
            r_cnt  <= '0;
        end else if (w_emit) begin
            r_addr <= r_addr + 32'(w_piece);
            r_left <= w_rem;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; a rejected request gives one zero entry flagged error
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_addr <= r_err ? 32'd0 : r_addr;
            r_out_len  <= r_err ? 16'd0 : w_piece;
            r_out_last <= w_last;
            r_out_err  <= r_err || w_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_len, r_out_addr};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

endmodule

FILE: rtl/dma_descriptor_table_builder.sv
// Top level of the DMA descriptor table builder.
// Uses dtb_pkg, dtb_front, dtb_queue and dtb_engine.
//
// Usage:
//   Slave stream takes one request per beat: tdata[31:0] is the buffer
//   address, tdata[63:32] the byte count. Master stream gives one descriptor
//   entry per beat: tdata[31:0] entry address, tdata[47:32] entry length,
//   tlast marks the table end, tuser flags an error (zero or oversized count,
//   or the table ran out of entries; then it rides on the final beat).
//   No entry crosses a 64 KiB boundary; a full aligned 64 KiB becomes two
//   32 KiB entries. At most MAX_ENTRIES entries per request.
//   The first entry passes the front-end holding register, the queue, the
//   generator working registers and the output register. The generator then
//   emits one entry per cycle unless the receiver stalls, with an idle state
//   between requests; the generator loop is the rate limit. The front end and
//   a two-entry queue keep taking requests while the generator works.
//   Reset clears all valid flags and returns the generator to idle.
//   When the receiver stalls, the output register holds its beat and the
//   generator waits; the queue then fills and the slave side deasserts tready.
module dma_descriptor_table_builder
    import dtb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] buffer_address, [63:32] total_bytes
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [31:0] entry_address, [47:32] entry_length
    output logic        o_m_tlast,   // last
    output logic        o_m_tuser    // error
);

    logic     w_f_valid;
    logic     w_f_ready;
    t_dtb_cmd w_f_cmd;
    logic     w_q_valid;
    logic     w_q_pop;
    t_dtb_cmd w_q_cmd;

    dtb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready),
        .o_cmd       (w_f_cmd)
    );

    dtb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_cmd   (w_f_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop        (w_q_pop),
        .o_pop_cmd    (w_q_cmd)
    );

    dtb_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_pop   (w_q_pop),
        .i_cmd       (w_q_cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

FILE: bench/tb.sv
// Testbench for dma_descriptor_table_builder: drives transfer requests on the
// slave stream and checks every descriptor entry against typed-in or predicted values.
// Depends on dtb_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;
    import dtb_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          NUM_DIR     = 18;
    localparam int          NUM_RANDOM  = 82;
    localparam int          TAIL_CYCLES = 16;
    localparam logic [31:0] SEG_BYTES   = 32'h0001_0000;
    localparam logic [31:0] HALF_SEG    = 32'h0000_8000;

    // One descriptor entry as seen on the master stream
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] len;
        logic        last;
        logic        err;
    } t_entry;

    // Directed request; known rows carry their single entry typed in
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] bytes;
        logic        known;
        t_entry      want;
    } t_row;

    // Shapes of random requests
    typedef enum int {
        RQ_SHORT,
        RQ_SPLIT,
        RQ_NEAR_FULL,
        RQ_HUGE,
        RQ_WRAP,
        RQ_BAD,
        RQ_ANY
    } t_req_kind;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_STRIDE
    } t_rx_mode;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // [31:0] buffer_address, [63:32] total_bytes
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // [31:0] entry_address, [47:32] entry_length
    logic        o_m_tlast;         // last
    logic        o_m_tuser;         // error

    t_entry   table_q[$];
    t_entry   head;
    t_row     dir_tab [NUM_DIR];
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_hold    = 0;
    int       burst_left = 0;
    int       cycle_cnt  = 0;
    int       fail_cnt   = 0;
    int       req_cnt    = 0;
    int       entry_cnt  = 0;
    int       err_cnt    = 0;
    int       ovf_cnt    = 0;

    dma_descriptor_table_builder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock, 20 ns period
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Expected table for one request: split at 64 KiB lines, full aligned
    // segments as two halves, error on the final entry when bytes remain once the table is full
    function automatic void predict_table(input logic [31:0] addr_in,
                                          input logic [31:0] bytes_in);
        logic [31:0] addr;
        logic [31:0] left;
        logic [31:0] chunk;
        logic [31:0] piece;
        int          pieces;
        int          n;
        bit          overflow;
        t_entry      held;
        addr     = addr_in;
        left     = bytes_in;
        n        = 0;
        overflow = 1'b0;
        held     = '0;
        // zero or oversized count: error-only entry
        if (bytes_in == 32'd0 || bytes_in > SIZE_LIMIT) begin
            held.last = 1'b1;
            held.err  = 1'b1;
            table_q.push_back(held);
            return;
        end
        while (left != 32'd0 && !overflow) begin
            chunk = SEG_BYTES - {16'h0, addr[15:0]};
            if (chunk > left)
                chunk = left;
            pieces = (chunk == SEG_BYTES) ? 2 : 1;
            piece  = (chunk == SEG_BYTES) ? HALF_SEG : chunk;
            for (int p = 0; p < pieces && !overflow; p++) begin
                if (n == MAX_ENTRIES) begin
                    overflow = 1'b1;
                end else begin
                    // entry is held back until we know whether it ends the table
                    if (n > 0)
                        table_q.push_back(held);
                    held = {addr, piece[15:0], 1'b0, 1'b0};
                    n++;
                    addr = addr + piece;
                    left = left - piece;
                end
            end
        end
        held.last = 1'b1;
        held.err  = overflow;
        table_q.push_back(held);
    endfunction

    function automatic t_row request_row(input logic [31:0] addr, input logic [31:0] bytes,
                                         input logic known, input logic [31:0] e_addr,
                                         input logic [15:0] e_len, input logic e_last,
                                         input logic e_err);
        return {addr, bytes, known, e_addr, e_len, e_last, e_err};
    endfunction

    // One request beat; bursts of random length with random, possibly empty, idle gaps between them
    task automatic send_request(input logic [31:0] addr, input logic [31:0] bytes,
                                input logic known, input t_entry want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {bytes, addr};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (known)
            table_q.push_back(want);
        else
            predict_table(addr, bytes);
        req_cnt++;
        @(negedge i_clk);
    endtask

    // Sender holds off until every expected entry has come out
    task automatic wait_table_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (table_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random request, mostly well-formed with a share of bad counts
    task automatic send_random();
        logic [31:0] addr;
        logic [31:0] bytes;
        int          pick;
        t_req_kind   kind;
        addr = $urandom;
        case ($urandom_range(0, 5))
            0, 1:    addr[15:0] = 16'h0000;
            2:       addr[15:0] = 16'hffff - 16'($urandom_range(0, 15));
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 35)      kind = RQ_SHORT;
        else if (pick < 50) kind = RQ_SPLIT;
        else if (pick < 65) kind = RQ_NEAR_FULL;
        else if (pick < 73) kind = RQ_HUGE;
        else if (pick < 83) kind = RQ_WRAP;
        else if (pick < 93) kind = RQ_BAD;
        else                kind = RQ_ANY;
        case (kind)
            RQ_SHORT:     bytes = $urandom_range(1, 32'h0003_ffff);
            RQ_SPLIT: begin
                addr[15:0] = 16'h0000;
                bytes = $urandom_range(1, 8) * SEG_BYTES;
                if ($urandom_range(0, 1) == 1)
                    bytes = bytes + $urandom_range(1, 32'hffff);
            end
            RQ_NEAR_FULL: bytes = $urandom_range(32'h001f_0000, 32'h0021_0000);
            RQ_HUGE:      bytes = $urandom_range(32'h0021_0001, SIZE_LIMIT);
            RQ_WRAP: begin
                addr  = 32'hffff_ffff - $urandom_range(0, 32'h0003_0000);
                bytes = $urandom_range(1, 32'h0006_0000);
            end
            RQ_BAD: begin
                if ($urandom_range(0, 1) == 1)
                    bytes = 32'd0;
                else
                    bytes = $urandom_range(SIZE_LIMIT + 1, 32'hffff_ffff);
            end
            default:      bytes = $urandom;
        endcase
        send_request(addr, bytes, 1'b0, '0);
    endtask

    // Receiver stall pattern, switching mode at random intervals
    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_hold <= $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0:       rx_mode <= RX_OPEN;
                1:       rx_mode <= RX_COIN;
                2:       rx_mode <= RX_SPARSE;
                default: rx_mode <= RX_STRIDE;
            endcase
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= (rx_hold % 3 == 0);
        endcase
    end

    // Entry checker: each accepted beat against the oldest expected entry
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            entry_cnt <= entry_cnt + 1;
            if (o_m_tuser) begin
                err_cnt <= err_cnt + 1;
                if (o_m_tdata[47:32] != 16'h0)
                    ovf_cnt <= ovf_cnt + 1;
            end
            if (table_q.size() == 0) begin
                $error("entry beat with nothing expected: addr %h len %h last %b err %b",
                       o_m_tdata[31:0], o_m_tdata[47:32], o_m_tlast, o_m_tuser);
                fail_cnt++;
            end else begin
                head = table_q.pop_front();
                if (o_m_tdata[31:0] !== head.addr) begin
                    $error("entry_address: expected %h, got %h", head.addr, o_m_tdata[31:0]);
                    fail_cnt++;
                end
                if (o_m_tdata[47:32] !== head.len) begin
                    $error("entry_length: expected %h, got %h", head.len, o_m_tdata[47:32]);
                    fail_cnt++;
                end
                if (o_m_tlast !== head.last) begin
                    $error("last: expected %b, got %b", head.last, o_m_tlast);
                    fail_cnt++;
                end
                if (o_m_tuser !== head.err) begin
                    $error("error: expected %b, got %b", head.err, o_m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    // Stimulus: directed table, then random requests
    initial begin
        // error-only results
        dir_tab[0]  = request_row(32'h0000_0000, 32'h0000_0000, 1'b1,
                                  32'h0, 16'h0, 1'b1, 1'b1);
        dir_tab[1]  = request_row(32'hffff_ffff, 32'h0000_0000, 1'b1,
                                  32'h0, 16'h0, 1'b1, 1'b1);
        dir_tab[2]  = request_row(32'h1234_5678, SIZE_LIMIT + 1, 1'b1,
                                  32'h0, 16'h0, 1'b1, 1'b1);
        dir_tab[3]  = request_row(32'hffff_ffff, 32'hffff_ffff, 1'b1,
                                  32'h0, 16'h0, 1'b1, 1'b1);
        dir_tab[4]  = request_row(32'h5555_aaaa, 32'haaaa_aaaa, 1'b1,
                                  32'h0, 16'h0, 1'b1, 1'b1);
        // single entries
        dir_tab[5]  = request_row(32'h0000_0000, 32'h0000_0001, 1'b1,
                                  32'h0000_0000, 16'h0001, 1'b1, 1'b0);
        dir_tab[6]  = request_row(32'hffff_ffff, 32'h0000_0001, 1'b1,
                                  32'hffff_ffff, 16'h0001, 1'b1, 1'b0);
        dir_tab[7]  = request_row(32'h0000_0000, 32'h0000_ffff, 1'b1,
                                  32'h0000_0000, 16'hffff, 1'b1, 1'b0);
        dir_tab[8]  = request_row(32'h0000_8000, 32'h0000_8000, 1'b1,
                                  32'h0000_8000, 16'h8000, 1'b1, 1'b0);
        // full aligned segment split in two halves
        dir_tab[9]  = request_row(32'h0001_0000, 32'h0001_0000, 1'b0, '0, '0, 1'b0, 1'b0);
        // crossing a 64 KiB line
        dir_tab[10] = request_row(32'h0000_fffe, 32'h0000_0004, 1'b0, '0, '0, 1'b0, 1'b0);
        // address wrap past the top of the space
        dir_tab[11] = request_row(32'hffff_fff0, 32'h0000_0020, 1'b0, '0, '0, 1'b0, 1'b0);
        dir_tab[12] = request_row(32'hffff_0000, 32'h0003_0000, 1'b0, '0, '0, 1'b0, 1'b0);
        // table exactly full, then one byte over
        dir_tab[13] = request_row(32'h0000_0000, 32'h0020_0000, 1'b0, '0, '0, 1'b0, 1'b0);
        dir_tab[14] = request_row(32'h0000_0000, 32'h0020_0001, 1'b0, '0, '0, 1'b0, 1'b0);
        // overflow where only the first half of a split segment fits
        dir_tab[15] = request_row(32'h0000_ff00, 32'h0020_0100, 1'b0, '0, '0, 1'b0, 1'b0);
        // largest legal count, then a short unaligned request
        dir_tab[16] = request_row(32'h8000_1234, SIZE_LIMIT, 1'b0, '0, '0, 1'b0, 1'b0);
        dir_tab[17] = request_row(32'haaaa_5555, 32'h0000_5555, 1'b0, '0, '0, 1'b0, 1'b0);

        // hold reset, then release it
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_DIR; i++)
            send_request(dir_tab[i].addr, dir_tab[i].bytes, dir_tab[i].known,
                         dir_tab[i].want);
        wait_table_drained();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM / 2)
                wait_table_drained();
            send_random();
        end

        // drain and let the pipeline settle
        wait_table_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (directed and random), %0d entry beats checked,",
                 req_cnt, entry_cnt);
        $display("%0d beats flagged error, %0d of them table overflows.", err_cnt, ovf_cnt);
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
